### src/scap_pkg.sv
// ----------------------------------------------------------------------------
// scap_pkg
// Shared widths, fixed-point constants, types and arithmetic helpers for the
// sine/cosine approximation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scap_pkg;

  // Port formats
  localparam int ANGLE_W          = 32;
  localparam int RESULT_W         = 32;
  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 30;

  // Range reduction (front)
  localparam int MAG_W   = ANGLE_W;                     // |angle| up to 2^31
  localparam int CONST_W = 33;                          // unsigned Q32 constants
  localparam logic [CONST_W-1:0] FOUR_OVER_PI_Q32 = 33'h1_45F3_06DD;
  localparam logic [CONST_W-1:0] HALF_PI_Q32      = 33'h1_921F_B544;
  localparam int PROD4_W = MAG_W + CONST_W;
  localparam int Q_SHIFT = ANGLE_FRAC_BITS + 32;
  localparam int Q_W     = PROD4_W - Q_SHIFT;           // octant count width
  localparam int KPI_W   = Q_W + CONST_W;
  localparam int RSHIFT  = 32 - ANGLE_FRAC_BITS;        // angle to Q32
  localparam int DIFF_W  = ((MAG_W + RSHIFT) > KPI_W ? (MAG_W + RSHIFT) : KPI_W) + 1;
  localparam int RED_W   = 35;                          // reduced angle, signed Q32

  // Polynomial evaluation (back), unsigned Q30
  localparam int QW = 31;
  localparam logic [QW-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [QW-1:0] CS1_Q30 = 31'd178916168;
  localparam logic [QW-1:0] CS2_Q30 = 31'd8754575;
  localparam logic [QW-1:0] CC1_Q30 = 31'd536875207;
  localparam logic [QW-1:0] CC2_Q30 = 31'd44755349;
  localparam logic [QW-1:0] CC3_Q30 = 31'd1491308;
  localparam logic [2*QW-1:0] ROUND_Q30 = (2*QW)'(1) << 29;

  localparam int RES_SHIFT = 30 - RESULT_FRAC_BITS;
  localparam logic [QW-1:0] RES_HALF = (QW'(1) << RES_SHIFT) >> 1;
  localparam logic [QW-1:0] RES_MAX  = QW'(1) << RESULT_FRAC_BITS;
  localparam logic signed [RESULT_W-1:0] RES_LIMIT = RESULT_W'(RES_MAX);

  // Decoupling queue; depth is a power of two and exceeds FRONT_STAGES + 1
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES = 3;
  localparam int FSTG_W       = $clog2(FRONT_STAGES + 1);
  localparam int BACK_STAGES  = 11;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } scap_quad_t;

  // Reduced item held in the queue
  typedef struct packed {
    scap_quad_t               quad;
    logic                     neg_in;
    logic signed [RED_W-1:0]  r;
  } scap_red_t;

  typedef struct packed {
    logic      push;
    scap_red_t data;
  } scap_push_t;

  // Q30 product, rounded half up
  function automatic logic [QW-1:0] mul_q30(input logic [QW-1:0] a,
                                             input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = ((2*QW)'(a) * (2*QW)'(b)) + ROUND_Q30;
    return p[30 +: QW];
  endfunction

  // Saturate to one, round to the result format, saturate again
  function automatic logic [QW-1:0] to_mag(input logic [QW-1:0] v);
    logic [QW-1:0] c;
    logic [QW-1:0] m;
    c = (v > ONE_Q30) ? ONE_Q30 : v;
    m = (c + RES_HALF) >> RES_SHIFT;
    return (m > RES_MAX) ? RES_MAX : m;
  endfunction

endpackage

`default_nettype wire

### src/scap_front.sv
// ----------------------------------------------------------------------------
// scap_front
// Takes angle items, forms |angle|, the quadrant count and the reduced angle,
// and pushes the reduced item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [scap_pkg::ANGLE_W-1:0]  angle,
  input  logic        [scap_pkg::QCNT_W-1:0]   queue_count,
  output logic                                 busy,
  output scap_pkg::scap_push_t                 push_out
);
  import scap_pkg::*;

  logic                  v1, v2, v3;
  logic [MAG_W-1:0]      s1_mag, s2_mag, s3_mag;
  logic                  s1_neg, s2_neg, s3_neg;
  logic [Q_W-1:0]        s2_q;
  logic [KPI_W-1:0]      s3_kpi;
  scap_quad_t            s3_quad;

  logic                  accept;
  logic [FSTG_W-1:0]     inflight;
  logic [MAG_W-1:0]      mag_in;
  logic [PROD4_W-1:0]    prod;
  logic [Q_W:0]          kp1;
  logic [Q_W-1:0]        k;
  logic [DIFF_W-1:0]     diff;

  // credit check: every item in flight already owns a queue slot
  assign inflight = FSTG_W'(v1) + FSTG_W'(v2) + FSTG_W'(v3);
  assign busy     = ((QCNT_W+1)'(queue_count) + (QCNT_W+1)'(inflight))
                    >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept   = start & ~busy;

  assign mag_in = angle[ANGLE_W-1] ? (~MAG_W'(angle) + 1'b1) : MAG_W'(angle);
  assign prod   = PROD4_W'(s1_mag) * PROD4_W'(FOUR_OVER_PI_Q32);
  assign kp1    = (Q_W+1)'(s2_q) + 1'b1;
  assign k      = kp1[Q_W:1];
  assign diff   = (DIFF_W'(s3_mag) << RSHIFT) - DIFF_W'(s3_kpi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mag <= mag_in;
      s1_neg <= angle[ANGLE_W-1];
    end
    s2_mag  <= s1_mag;
    s2_neg  <= s1_neg;
    s2_q    <= prod[Q_SHIFT +: Q_W];
    s3_mag  <= s2_mag;
    s3_neg  <= s2_neg;
    s3_kpi  <= KPI_W'(k) * KPI_W'(HALF_PI_Q32);
    s3_quad <= scap_quad_t'(k[1:0]);
  end

  always_comb begin
    push_out.push        = v3;
    push_out.data.quad   = s3_quad;
    push_out.data.neg_in = s3_neg;
    push_out.data.r      = signed'(diff[RED_W-1:0]);
  end

endmodule

`default_nettype wire

### src/scap_queue.sv
// ----------------------------------------------------------------------------
// scap_queue
// Short first-in first-out queue of reduced items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  scap_pkg::scap_push_t          push_in,
  input  logic                          pop,
  output scap_pkg::scap_red_t           head,
  output logic                          empty,
  output logic                          full,
  output logic [scap_pkg::QCNT_W-1:0]   count
);
  import scap_pkg::*;

  scap_red_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      entries[wr_ptr] <= push_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push_in.push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### src/scap_back.sv
// ----------------------------------------------------------------------------
// scap_back
// Polynomial pipeline: rounds the reduced angle to Q30, evaluates the sine
// and cosine polynomials, saturates and applies quadrant and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  empty,
  input  scap_pkg::scap_red_t                   head,
  output logic                                  pop,
  output logic                                  done,
  output logic signed [scap_pkg::RESULT_W-1:0]  sine,
  output logic signed [scap_pkg::RESULT_W-1:0]  cosine
);
  import scap_pkg::*;

  typedef struct packed {
    scap_quad_t quad;
    logic       neg_in;
    logic       r_neg;
  } scap_side_t;

  logic [BACK_STAGES-1:0]   v;
  scap_side_t               side [BACK_STAGES-1];

  logic signed [RED_W-1:0]  b0_r;
  logic [QW-1:0]            b1_r30, b2_r30, b3_r30, b4_r30, b5_r30, b6_r30;
  logic [QW-1:0]            b2_xx, b3_xx, b4_xx, b5_xx, b6_xx;
  logic [QW-1:0]            b3_a, b3_b, b4_t1, b4_u1, b5_a, b5_b, b6_t2, b6_u2;
  logic [QW-1:0]            b7_ss, b7_m, b8_ss, b8_cc, b9_smag, b9_cmag;

  logic [RED_W-1:0]         rmag;
  logic [RED_W-1:0]         rrnd;
  logic [QW-1:0]            sel_s, sel_c;
  logic                     neg_s, neg_c;

  function automatic logic [RESULT_W-1:0] signed_res(input logic [QW-1:0] mag,
                                                      input logic neg);
    logic [RESULT_W-1:0] e;
    e = RESULT_W'(mag);
    return neg ? (~e + 1'b1) : e;
  endfunction

  assign pop  = ~empty;
  assign done = v[BACK_STAGES-1];

  assign rmag = b0_r[RED_W-1] ? (~b0_r + 1'b1) : b0_r;
  assign rrnd = rmag + RED_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[BACK_STAGES-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    side[0] <= '{quad: head.quad, neg_in: head.neg_in, r_neg: 1'b0};
    side[1] <= '{quad: side[0].quad, neg_in: side[0].neg_in, r_neg: b0_r[RED_W-1]};
    for (int i = 2; i < BACK_STAGES-1; i++) begin
      side[i] <= side[i-1];
    end

    b0_r    <= head.r;
    b1_r30  <= rrnd[2 +: QW];
    b2_xx   <= mul_q30(b1_r30, b1_r30);
    b2_r30  <= b1_r30;
    b3_a    <= mul_q30(b2_xx, CS2_Q30);
    b3_b    <= mul_q30(b2_xx, CC3_Q30);
    b3_xx   <= b2_xx;
    b3_r30  <= b2_r30;
    b4_t1   <= CS1_Q30 - b3_a;
    b4_u1   <= CC2_Q30 - b3_b;
    b4_xx   <= b3_xx;
    b4_r30  <= b3_r30;
    b5_a    <= mul_q30(b4_xx, b4_t1);
    b5_b    <= mul_q30(b4_xx, b4_u1);
    b5_xx   <= b4_xx;
    b5_r30  <= b4_r30;
    b6_t2   <= ONE_Q30 - b5_a;
    b6_u2   <= CC1_Q30 - b5_b;
    b6_xx   <= b5_xx;
    b6_r30  <= b5_r30;
    b7_ss   <= mul_q30(b6_r30, b6_t2);
    b7_m    <= mul_q30(b6_xx, b6_u2);
    b8_ss   <= b7_ss;
    b8_cc   <= ONE_Q30 - b7_m;
    b9_smag <= to_mag(b8_ss);
    b9_cmag <= to_mag(b8_cc);
    sine    <= signed'(signed_res(sel_s, neg_s ^ side[BACK_STAGES-2].neg_in));
    cosine  <= signed'(signed_res(sel_c, neg_c));
  end

  // quadrant: (S,C), (C,-S), (-S,-C), (-C,S); S carries the sign of r
  always_comb begin
    unique case (side[BACK_STAGES-2].quad)
      QUAD_0: begin
        sel_s = b9_smag;  neg_s = side[BACK_STAGES-2].r_neg;
        sel_c = b9_cmag;  neg_c = 1'b0;
      end
      QUAD_1: begin
        sel_s = b9_cmag;  neg_s = 1'b0;
        sel_c = b9_smag;  neg_c = ~side[BACK_STAGES-2].r_neg;
      end
      QUAD_2: begin
        sel_s = b9_smag;  neg_s = ~side[BACK_STAGES-2].r_neg;
        sel_c = b9_cmag;  neg_c = 1'b1;
      end
      QUAD_3: begin
        sel_s = b9_cmag;  neg_s = 1'b1;
        sel_c = b9_smag;  neg_c = side[BACK_STAGES-2].r_neg;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/sine_cosine_approx_unit.sv
// ----------------------------------------------------------------------------
// sine_cosine_approx_unit
// Sine and cosine of a Q24 angle in radians, both results in Q30.
// ----------------------------------------------------------------------------
// One angle item is taken on each rising edge where start is high and busy is
// low, one item per clock at full rate. Each item gives one result: sine and
// cosine appear together with done high for exactly one cycle, in the order
// the items came in. The receiver cannot hold results off. On its way each
// item passes the 3-stage range reduction (absolute value, multiply by 4/pi,
// multiply by pi/2 and subtract), whose first register is loaded by the
// taking edge, then the queue, then the 11-stage polynomial pipeline
// (capture, round to Q30, multiply and subtract stages in turn on both
// polynomials, saturation, then quadrant and sign). busy is a credit check
// on the 8-entry queue; as the back end drains one item a cycle it does not
// rise in normal use. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_approx_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [scap_pkg::ANGLE_W-1:0]   angle,
  output logic                                  done,
  output logic signed [scap_pkg::RESULT_W-1:0]  sine,
  output logic signed [scap_pkg::RESULT_W-1:0]  cosine
);
  import scap_pkg::*;

  // front -> queue
  scap_push_t           front_push;
  // queue -> back
  scap_red_t            q_head;
  logic                 q_empty;
  logic                 q_full;
  logic                 q_pop;
  logic [QCNT_W-1:0]    q_count;

  // Front: |angle|, quadrant count k = (floor(|x|*4/pi)+1)/2, r = |x| - k*pi/2
  scap_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .angle       (angle),
    .queue_count (q_count),
    .busy        (busy),
    .push_out    (front_push)
  );

  // Queue: decouples reduction from evaluation
  scap_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (front_push),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full),
    .count   (q_count)
  );

  // Back: polynomials, saturation, quadrant swap and signs
  scap_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .done   (done),
    .sine   (sine),
    .cosine (cosine)
  );

`ifndef ASSERT_OFF
  // credit check must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_push.push |-> !q_full)
    else $error("queue push while full");

  // every result strobe traces back to exactly one queue pop
  a_done_from_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_pop, BACK_STAGES))
    else $error("result strobe without matching pop");

  // saturation keeps both results within plus or minus one
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (sine <= RES_LIMIT) && (sine >= -RES_LIMIT) &&
             (cosine <= RES_LIMIT) && (cosine >= -RES_LIMIT))
    else $error("result out of range");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sine_cosine_approx_unit. Angle items go in through
// the start/busy handshake with random gaps; a bit-exact fixed-point model of
// the range reduction and both polynomials predicts every sine/cosine pair,
// and a scoreboard checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

  import scap_pkg::ANGLE_W;
  import scap_pkg::RESULT_W;
  import scap_pkg::ANGLE_FRAC_BITS;
  import scap_pkg::RESULT_FRAC_BITS;
  import scap_pkg::scap_quad_t;
  import scap_pkg::QUAD_0;
  import scap_pkg::QUAD_1;
  import scap_pkg::QUAD_2;
  import scap_pkg::QUAD_3;

  // Fixed-point constants, kept independent of the design's own copies
  localparam longint unsigned OCTANTS_PER_RAD = 64'h1_45F3_06DD;  // 4/pi, Q32
  localparam longint unsigned QUARTER_TURN    = 64'h1_921F_B544;  // pi/2, Q32
  localparam longint unsigned UNITY_Q30       = 64'h4000_0000;
  localparam longint unsigned SIN_C1          = 64'd178916168;    // 1/6 - 38e-6
  localparam longint unsigned SIN_C2          = 64'd8754575;      // 1/120 - 180e-6
  localparam longint unsigned COS_C1          = 64'd536875207;    // 1/2 + 4e-6
  localparam longint unsigned COS_C2          = 64'd44755349;     // 1/24 + 15e-6
  localparam longint unsigned COS_C3          = 64'd1491308;      // 1/720

  localparam int N_RANDOM     = 400;
  localparam int BLOCK_ITEMS  = 50;
  localparam int MAX_GAP      = 13;
  localparam int PIPE_LATENCY = 14;     // edges from item taken to done
  localparam int QUIET_LIMIT  = 1000;   // cycles with no handshake at all

  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [RESULT_W-1:0] trig_t;

  typedef struct {
    angle_t angle;
    trig_t  sine;
    trig_t  cosine;
  } trig_pair_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds predicted sine/cosine pairs in arrival order
  // --------------------------------------------------------------------------
  class trig_scoreboard;
    trig_pair_t  pending_pairs[$];
    int unsigned mismatches;
    int unsigned results_checked;

    // Q30 product, rounded half up
    static function longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Clamp a Q30 magnitude to one, round to the result format, apply sign
    static function longint signed to_result_fmt(longint unsigned m, bit neg);
      longint unsigned sh;
      longint unsigned half;
      longint unsigned lim;
      sh   = 30 - RESULT_FRAC_BITS;
      half = (64'd1 << sh) >> 1;
      lim  = 64'd1 << RESULT_FRAC_BITS;
      if (m > UNITY_Q30) m = UNITY_Q30;
      m = (m + half) >> sh;
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    static function trig_pair_t predict_sin_cos(angle_t a);
      trig_pair_t      p;
      bit              a_neg;
      bit              r_neg;
      longint unsigned mag;
      longint unsigned octant;
      longint unsigned quad_n;
      longint signed   red;
      longint unsigned red_mag;
      longint unsigned r30;
      longint unsigned r2;
      longint unsigned t;
      longint unsigned s_mag;
      longint unsigned c_mag;
      longint signed   s_val;
      longint signed   c_val;
      longint signed   s_out;
      longint signed   c_out;
      scap_quad_t      quad;
      a_neg  = a[ANGLE_W-1];
      mag    = a_neg ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
      // nearest multiple of pi/2 from the octant count
      octant = (mag * OCTANTS_PER_RAD) >> (ANGLE_FRAC_BITS + 32);
      quad_n = (octant + 1) >> 1;
      red    = longint'(mag << (32 - ANGLE_FRAC_BITS)) - longint'(quad_n * QUARTER_TURN);
      r_neg  = red < 0;
      red_mag = r_neg ? longint'(-red) : longint'(red);
      r30    = (red_mag + 2) >> 2;
      r2     = q30_mul(r30, r30);
      // odd polynomial for sine
      t      = SIN_C1 - q30_mul(r2, SIN_C2);
      t      = UNITY_Q30 - q30_mul(r2, t);
      s_mag  = q30_mul(r30, t);
      // even polynomial for cosine
      t      = COS_C2 - q30_mul(r2, COS_C3);
      t      = COS_C1 - q30_mul(r2, t);
      c_mag  = UNITY_Q30 - q30_mul(r2, t);
      s_val  = to_result_fmt(s_mag, r_neg);
      c_val  = to_result_fmt(c_mag, 1'b0);
      quad   = scap_quad_t'(quad_n[1:0]);
      case (quad)
        QUAD_0: begin s_out = s_val;  c_out = c_val;  end
        QUAD_1: begin s_out = c_val;  c_out = -s_val; end
        QUAD_2: begin s_out = -s_val; c_out = -c_val; end
        default: begin s_out = -c_val; c_out = s_val; end
      endcase
      if (a_neg) s_out = -s_out;
      p.angle  = a;
      p.sine   = trig_t'(s_out);
      p.cosine = trig_t'(c_out);
      return p;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task note_angle(angle_t a);
      pending_pairs.push_back(predict_sin_cos(a));
    endtask

    task check_result(trig_t s, trig_t c);
      trig_pair_t want;
      if (pending_pairs.size() == 0) begin
        report($sformatf("unexpected result sine %h cosine %h", s, c));
      end else begin
        want = pending_pairs.pop_front();
        results_checked++;
        if (s !== want.sine)
          report($sformatf("angle %h: sine %h, predicted %h", want.angle, s, want.sine));
        if (c !== want.cosine)
          report($sformatf("angle %h: cosine %h, predicted %h", want.angle, c,
                           want.cosine));
      end
    endtask

    function int pending();
      return pending_pairs.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  angle_t angle;
  logic   done;
  trig_t  sine;
  trig_t  cosine;

  trig_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    quiet_cycles;

  sine_cosine_approx_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .angle  (angle),
    .done   (done),
    .sine   (sine),
    .cosine (cosine)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // k quarter-pi steps as a Q24 angle (odd k sits on a reduction boundary)
  function automatic longint signed quarter_pi_steps(int k);
    return (longint'(k) * longint'(QUARTER_TURN)) >>> 9;
  endfunction

  function automatic angle_t pick_angle();
    longint signed v;
    case ($urandom_range(0, 9)) inside
      [0:2]: v = longint'(angle_t'($urandom()));
      [3:5]: v = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
      [6:7]: begin
        // close to k*pi/4, both signs; 162 keeps it inside the range
        v = quarter_pi_steps($urandom_range(1, 162)) + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        // near either end of the range
        if ($urandom_range(0, 1)) v = 64'sh7FFF_FFFF - $urandom_range(0, 255);
        else                      v = -64'sh8000_0000 + $urandom_range(0, 255);
      end
    endcase
    return angle_t'(v);
  endfunction

  // One item: optional idle gap, optional drain, then hold start until taken
  task send_angle(angle_t a, int gap, bit drain);
    if (gap > 0 || (drain && sb.pending() > 0)) begin
      start <= 1'b0;
      angle <= angle_t'($urandom());   // junk while idle, must be ignored
      repeat (gap) @(posedge clk);
      while (drain && sb.pending() > 0) @(posedge clk);
    end
    start <= 1'b1;
    angle <= a;
    do @(posedge clk); while (busy);
    sb.note_angle(a);
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Result monitor and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(done))
        sb.report("done is unknown");
      else if (done)
        sb.check_result(sine, cosine);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    angle_t directed[$];
    int     mode;
    int     gap;
    sb           = new();
    items_sent   = 0;
    quiet_cycles = 0;
    rst   = 1'b1;
    start = 1'b0;
    angle = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, tiny, range ends, one radian, pi/4 multiples either side
    directed = '{angle_t'(0), angle_t'(1), angle_t'(-1), angle_t'(2),
                 angle_t'(32'h7FFF_FFFF), angle_t'(32'h8000_0000),
                 angle_t'(32'h8000_0001), angle_t'(32'h0100_0000),
                 angle_t'(-32'sh0100_0000), angle_t'(32'h5555_5555),
                 angle_t'(32'hAAAA_AAAA), angle_t'(32'h00FF_FFFF)};
    for (int k = 1; k <= 8; k++) begin
      directed.push_back(angle_t'(quarter_pi_steps(k)));
      directed.push_back(angle_t'(quarter_pi_steps(k) + 1));
    end
    directed.push_back(angle_t'(-quarter_pi_steps(2)));
    directed.push_back(angle_t'(-quarter_pi_steps(4)));
    directed.push_back(angle_t'(-quarter_pi_steps(3) - 1));
    foreach (directed[i])
      send_angle(directed[i], (i < 15) ? 0 : $urandom_range(0, MAX_GAP), 1'b0);

    // Random blocks: back to back, fully random gaps, or mostly dense;
    // the first item of the first block waits for the pipe to empty
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % BLOCK_ITEMS == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       gap = 0;
        1:       gap = $urandom_range(0, MAX_GAP);
        default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
      send_angle(pick_angle(), gap,
                 (i == 0) || (i % BLOCK_ITEMS == 0 && $urandom_range(0, 1)));
    end
    start <= 1'b0;

    // Drain, then let the pipe run on a little to catch stray strobes
    while (sb.pending() > 0) @(posedge clk);
    repeat (PIPE_LATENCY + 6) @(posedge clk);
    foreach (sb.pending_pairs[i])
      sb.report($sformatf("no result for angle %h", sb.pending_pairs[i].angle));

    $display("Summary: %0d angles sent, %0d sine/cosine pairs checked, %0d mismatches",
             items_sent, sb.results_checked, sb.mismatches);
    $display("Covered: zero, range ends, pi/4 boundaries, full-range and small angles,");
    $display("         back-to-back and gapped input, pipe drained mid-run");
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
